>>> hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared operation codes, word types and field limits.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int unsigned FieldW = 32;
    localparam int unsigned KindW  = 3;

    localparam logic [KindW-1:0] KIND_ADD  = 3'd0;
    localparam logic [KindW-1:0] KIND_SUB  = 3'd1;
    localparam logic [KindW-1:0] KIND_MUL  = 3'd2;
    localparam logic [KindW-1:0] KIND_DIV  = 3'd3;
    localparam logic [KindW-1:0] KIND_CONJ = 3'd4;
    localparam logic [KindW-1:0] KIND_MAG2 = 3'd5;

    typedef struct packed {
        logic        [KindW-1:0]  kind;
        logic signed [FieldW-1:0] a_re;
        logic signed [FieldW-1:0] a_im;
        logic signed [FieldW-1:0] b_re;
        logic signed [FieldW-1:0] b_im;
    } t_in_word;

    typedef struct packed {
        logic signed [FieldW-1:0] res_re;
        logic signed [FieldW-1:0] res_im;
        logic                     overflow;
        logic                     divide_by_zero;
    } t_out_word;

endpackage

>>> hw/rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate and squared magnitude on
// signed fixed-point complex words, saturated with overflow flag.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle when the output does not stall. Every word,
// whatever its kind, passes a fixed pipeline: operand register, product
// register, product sum register, divider input register, a restoring divider
// with one stage per numerator bit (2*EW+FRAC_BITS+2 stages; the divide path
// sets the latency, other kinds ride alongside in the tag), and a result
// register. A stall on the output freezes the whole pipeline; the input is
// taken while the output register is free or being drained.
module complex_arithmetic_unit #(
    parameter int unsigned WIDTH     = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cau_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output cau_pkg::t_out_word  o_data
);
    localparam int unsigned EW  = (WIDTH < 32) ? WIDTH : 32;
    localparam int unsigned PW  = 2 * EW + 2;          // product sum width
    localparam int unsigned MW  = PW;                  // magnitude width
    localparam int unsigned NW  = MW + FRAC_BITS;      // divider numerator
    localparam int unsigned QW  = 64;
    localparam int unsigned KW  = cau_pkg::KindW;
    // real lane tag: kind, dz, sign, simple real result and overflow
    localparam int unsigned TR  = KW + 1 + 1 + EW + 1;
    // imaginary lane tag: sign, simple imaginary result
    localparam int unsigned TI  = 1 + EW;

    // saturate sign and magnitude to EW bits; top bit is overflow
    function automatic logic [EW:0] sat_mag(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim_m;
        lim_m = MW'(1) << (EW - 1);
        if (neg) begin
            if (mag > lim_m) begin
                return {1'b1, 1'b1, {(EW-1){1'b0}}};
            end
            return {1'b0, EW'(MW'(0) - mag)};
        end
        if (mag > lim_m - MW'(1)) begin
            return {1'b1, 1'b0, {(EW-1){1'b1}}};
        end
        return {1'b0, mag[EW-1:0]};
    endfunction

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // stage 1: operands
    logic                 r1_vld;
    logic [KW-1:0]        r1_kind;
    logic signed [EW-1:0] r1_ar, r1_ai, r1_br, r1_bi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (en)  r1_vld <= i_valid;
        if (en) begin
            r1_kind <= i_data.kind;
            r1_ar   <= i_data.a_re[EW-1:0];
            r1_ai   <= i_data.a_im[EW-1:0];
            r1_br   <= i_data.b_re[EW-1:0];
            r1_bi   <= i_data.b_im[EW-1:0];
        end
    end

    // stage 2: products and the simple results
    logic               s_ov;
    logic signed [EW-1:0] n_lo [2];
    logic signed [EW:0]   n_sv [2];
    always_comb begin
        n_sv[0] = '0;
        n_sv[1] = '0;
        case (r1_kind)
            cau_pkg::KIND_ADD: begin
                n_sv[0] = {r1_ar[EW-1], r1_ar} + {r1_br[EW-1], r1_br};
                n_sv[1] = {r1_ai[EW-1], r1_ai} + {r1_bi[EW-1], r1_bi};
            end
            cau_pkg::KIND_SUB: begin
                n_sv[0] = {r1_ar[EW-1], r1_ar} - {r1_br[EW-1], r1_br};
                n_sv[1] = {r1_ai[EW-1], r1_ai} - {r1_bi[EW-1], r1_bi};
            end
            cau_pkg::KIND_CONJ: begin
                n_sv[0] = {r1_ar[EW-1], r1_ar};
                n_sv[1] = -{r1_ai[EW-1], r1_ai};
            end
            default: ;
        endcase
    end
    // saturate the simple sums
    always_comb begin
        s_ov = 1'b0;
        for (int k = 0; k < 2; k++) begin
            if (n_sv[k][EW] != n_sv[k][EW-1]) begin
                s_ov    = 1'b1;
                n_lo[k] = n_sv[k][EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
            end else begin
                n_lo[k] = n_sv[k][EW-1:0];
            end
        end
    end

    logic                   r2_vld;
    logic [KW-1:0]          r2_kind;
    logic signed [2*EW-1:0] r2_p [6];
    logic [EW-1:0]          r2_sr, r2_si;
    logic                   r2_sov, r2_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (en)  r2_vld <= r1_vld;
        if (en) begin
            r2_kind <= r1_kind;
            r2_sr   <= n_lo[0];
            r2_si   <= n_lo[1];
            r2_sov  <= s_ov;
            r2_dz   <= (r1_br == '0) && (r1_bi == '0);
            r2_p[4] <= r1_br * r1_br;
            r2_p[5] <= r1_bi * r1_bi;
            if (r1_kind == cau_pkg::KIND_MAG2) begin
                r2_p[0] <= r1_ar * r1_ar;
                r2_p[1] <= r1_ai * r1_ai;
                r2_p[2] <= r1_ar * r1_bi;
                r2_p[3] <= r1_ai * r1_br;
            end else begin
                r2_p[0] <= r1_ar * r1_br;
                r2_p[1] <= r1_ai * r1_bi;
                r2_p[2] <= r1_ar * r1_bi;
                r2_p[3] <= r1_ai * r1_br;
            end
        end
    end

    // stage 3: product sums, sign and magnitude, divisor
    logic signed [PW-1:0] n_re, n_im;
    logic [PW-1:0]        n_den;
    always_comb begin
        n_den = PW'(r2_p[4]) + PW'(r2_p[5]);
        case (r2_kind)
            cau_pkg::KIND_MUL: begin
                n_re = PW'(r2_p[0]) - PW'(r2_p[1]);
                n_im = PW'(r2_p[2]) + PW'(r2_p[3]);
            end
            cau_pkg::KIND_DIV: begin
                n_re = PW'(r2_p[0]) + PW'(r2_p[1]);
                n_im = PW'(r2_p[3]) - PW'(r2_p[2]);
            end
            default: begin
                n_re = PW'(r2_p[0]) + PW'(r2_p[1]);
                n_im = '0;
            end
        endcase
    end

    logic                 r3_vld;
    logic [KW-1:0]        r3_kind;
    logic [MW-1:0]        r3_mre, r3_mim;
    logic                 r3_nre, r3_nim;
    logic [PW-1:0]        r3_den;
    logic [EW-1:0]        r3_sr, r3_si;
    logic                 r3_sov, r3_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (en)  r3_vld <= r2_vld;
        if (en) begin
            r3_kind <= r2_kind;
            r3_nre  <= n_re[PW-1];
            r3_nim  <= n_im[PW-1];
            r3_mre  <= n_re[PW-1] ? MW'(-n_re) : MW'(n_re);
            r3_mim  <= n_im[PW-1] ? MW'(-n_im) : MW'(n_im);
            r3_den  <= n_den;
            r3_sr   <= r2_sr;
            r3_si   <= r2_si;
            r3_sov  <= r2_sov;
            r3_dz   <= r2_dz;
        end
    end

    // scale product sums back by FRAC_BITS, flooring, and saturate
    logic [MW-1:0] bias, sc_re, sc_im;
    logic [EW:0]   sat_re, sat_im;
    assign bias   = (MW'(1) << FRAC_BITS) - MW'(1);
    assign sc_re  = (r3_nre ? r3_mre + bias : r3_mre) >> FRAC_BITS;
    assign sc_im  = (r3_nim ? r3_mim + bias : r3_mim) >> FRAC_BITS;
    assign sat_re = sat_mag(r3_nre, sc_re);
    assign sat_im = sat_mag(r3_nim, sc_im);

    // pick the result that rides alongside the divider
    logic [EW-1:0] t_sr, t_si;
    logic          t_sov;
    always_comb begin
        if (r3_kind == cau_pkg::KIND_MUL || r3_kind == cau_pkg::KIND_MAG2) begin
            t_sr  = sat_re[EW-1:0];
            t_si  = sat_im[EW-1:0];
            t_sov = sat_re[EW] || sat_im[EW];
        end else begin
            t_sr  = r3_sr;
            t_si  = r3_si;
            t_sov = r3_sov;
        end
    end

    // divider lanes; the other results travel in the tags
    logic [TR-1:0] tag_re_in, tag_re_out;
    logic [TI-1:0] tag_im_in, tag_im_out;
    assign tag_re_in = {r3_kind, r3_dz, r3_nre, t_sr, t_sov};
    assign tag_im_in = {r3_nim, t_si};

    logic [NW-1:0] num_re, num_im;
    assign num_re = NW'(r3_mre) << FRAC_BITS;
    assign num_im = NW'(r3_mim) << FRAC_BITS;

    // divisor: |b|^2 on a divide by nonzero b, one otherwise
    logic [PW-1:0] den;
    assign den = (r3_kind == cau_pkg::KIND_DIV && !r3_dz) ? r3_den : PW'(1);

    logic          d_vld, d_vld2;
    logic [QW-1:0] q_re, q_im;
    cau_divider #(.NW(NW), .DW(PW), .QW(QW), .TW(TR)) u_div_re (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r3_vld),
        .i_num(num_re), .i_den(den), .i_tag(tag_re_in),
        .o_vld(d_vld), .o_quo(q_re), .o_tag(tag_re_out)
    );
    cau_divider #(.NW(NW), .DW(PW), .QW(QW), .TW(TI)) u_div_im (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r3_vld),
        .i_num(num_im), .i_den(den), .i_tag(tag_im_in),
        .o_vld(d_vld2), .o_quo(q_im), .o_tag(tag_im_out)
    );

    // final stage: saturate and choose
    logic [KW-1:0]  f_kind;
    logic           f_dz, f_nre, f_nim, f_sov;
    logic [EW-1:0]  f_sr, f_si;
    assign {f_kind, f_dz, f_nre, f_sr, f_sov} = tag_re_out;
    assign {f_nim, f_si} = tag_im_out;

    logic [QW-1:0] lim;
    assign lim = QW'(1) << (EW - 1);

    logic [EW-1:0] v_re, v_im;
    logic          o_re, o_im;
    always_comb begin
        o_re = 1'b0;
        o_im = 1'b0;
        if (f_nre) begin
            if (q_re > lim) begin o_re = 1'b1; v_re = {1'b1, {(EW-1){1'b0}}}; end
            else v_re = EW'(-q_re);
        end else begin
            if (q_re > lim - QW'(1)) begin o_re = 1'b1; v_re = {1'b0, {(EW-1){1'b1}}}; end
            else v_re = q_re[EW-1:0];
        end
        if (f_nim) begin
            if (q_im > lim) begin o_im = 1'b1; v_im = {1'b1, {(EW-1){1'b0}}}; end
            else v_im = EW'(-q_im);
        end else begin
            if (q_im > lim - QW'(1)) begin o_im = 1'b1; v_im = {1'b0, {(EW-1){1'b1}}}; end
            else v_im = q_im[EW-1:0];
        end
    end

    cau_pkg::t_out_word n_out;
    always_comb begin
        n_out = '0;
        case (f_kind)
            cau_pkg::KIND_ADD, cau_pkg::KIND_SUB, cau_pkg::KIND_CONJ,
            cau_pkg::KIND_MUL, cau_pkg::KIND_MAG2: begin
                n_out.res_re   = cau_pkg::FieldW'(signed'(f_sr));
                n_out.res_im   = cau_pkg::FieldW'(signed'(f_si));
                n_out.overflow = f_sov;
            end
            cau_pkg::KIND_DIV: begin
                if (f_dz) begin
                    n_out.divide_by_zero = 1'b1;
                end else begin
                    n_out.res_re   = cau_pkg::FieldW'(signed'(v_re));
                    n_out.res_im   = cau_pkg::FieldW'(signed'(v_im));
                    n_out.overflow = o_re || o_im;
                end
            end
            default: ;
        endcase
    end

    // output register
    logic               r_ovld;
    cau_pkg::t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (en)  r_ovld <= d_vld & d_vld2;
        if (en) r_out <= n_out;
    end
    assign o_valid = r_ovld;
    assign o_data  = r_out;
endmodule

>>> hw/rtl/cau_divider.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Quotient saturates to all ones once it exceeds 2^(QW-2).
// ----------------------------------------------------------------------------
module cau_divider #(
    parameter int unsigned NW = 80,   // numerator width
    parameter int unsigned DW = 64,   // divisor width
    parameter int unsigned QW = 34,   // quotient bits kept
    parameter int unsigned TW = 8     // tag width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    // stage s holds remainder, remaining numerator bits, quotient
    logic          r_vld [NW+1];
    logic [DW:0]   r_rem [NW+1];
    logic [NW-1:0] r_num [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic [QW-1:0] r_quo [NW+1];
    logic          r_big [NW+1];
    logic [TW-1:0] r_tag [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_big[0] <= 1'b0;
            r_tag[0] <= i_tag;
        end
    end

    // one quotient bit per stage
    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW:0]   n_rem;
        logic          n_qb;
        always_comb begin
            n_rem = {r_rem[s][DW-1:0], r_num[s][NW-1]};
            n_qb  = (n_rem >= {1'b0, r_den[s]});
            if (n_qb) begin
                n_rem = n_rem - {1'b0, r_den[s]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_num[s+1] <= r_num[s] << 1;
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
                if (r_big[s] || (r_quo[s] > (QW'(1) << (QW-2)))) begin
                    r_big[s+1] <= 1'b1;
                    r_quo[s+1] <= r_quo[s];
                end else begin
                    r_big[s+1] <= 1'b0;
                    r_quo[s+1] <= {r_quo[s][QW-2:0], n_qb};
                end
            end
        end
    end

    assign o_vld = r_vld[NW];
    assign o_quo = r_big[NW] ? '1 : r_quo[NW];
    assign o_tag = r_tag[NW];
endmodule

>>> hw/rtl/cau_checker.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level properties of the result stream.
// ----------------------------------------------------------------------------
module cau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input cau_pkg::t_out_word o_data
);
    // hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed under stall");

    // ready drops only while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output stall");

    // flags never both set
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.overflow && o_data.divide_by_zero))
        else $error("overflow with divide by zero");

    // divide by zero gives zero
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.divide_by_zero |-> o_data.res_re == '0 && o_data.res_im == '0)
        else $error("nonzero result on divide by zero");
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
